// ----- hw/rtl/gamepad_report_format_and_send_defines.svh -----
// Assertion macros for the gamepad report formatter.
`ifndef GAMEPAD_REPORT_FORMAT_AND_SEND_DEFINES_SVH
`define GAMEPAD_REPORT_FORMAT_AND_SEND_DEFINES_SVH

`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset.
`define GRFS_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("grfs: check failed");
// Antecedent implies consequent in the same cycle.
`define GRFS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grfs: implication failed");
`else
`define GRFS_ASSERT(lbl, cond)
`define GRFS_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/grfs_pkg.sv -----
// Types, codes and report-building functions for the gamepad report formatter.
package grfs_pkg;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// register index is paddr[2]
	localparam logic REG_IDX_THRESHOLD = 1'b0;
	localparam logic [7:0] THRESHOLD_RESET = 8'd32;

	localparam logic [3:0] HAT_CENTER  = 4'h0f;
	localparam logic [7:0] AXIS_CENTER = 8'h80;

	typedef enum logic [2:0] {
		KIND_INPUT      = 3'd0,
		KIND_DONE       = 3'd1,
		KIND_FAIL       = 3'd2,
		KIND_TICK       = 3'd3,
		KIND_LINK_RESET = 3'd4
	} kind_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [9:0]         face_buttons;
		logic [3:0]         dpad;
		logic [7:0]         left_trigger;
		logic [7:0]         right_trigger;
		logic signed [15:0] stick_lx;
		logic signed [15:0] stick_ly;
		logic signed [15:0] stick_rx;
		logic signed [15:0] stick_ry;
		logic               slot_active;
		logic               link_ready;
	} in_item_t;

	typedef struct packed {
		logic        start_send;
		logic [11:0] out_buttons;
		logic [3:0]  out_hat;
		logic [7:0]  out_lx;
		logic [7:0]  out_ly;
		logic [7:0]  out_rx;
		logic [7:0]  out_ry;
		logic        busy_flag;
		logic        waiting_flag;
	} out_item_t;

	typedef struct packed {
		logic [11:0] buttons;
		logic [3:0]  hat;
		logic [7:0]  lx;
		logic [7:0]  ly;
		logic [7:0]  rx;
		logic [7:0]  ry;
	} report_t;

	localparam report_t NEUTRAL_REPORT = '{
		buttons: 12'd0,
		hat:     HAT_CENTER,
		lx:      AXIS_CENTER,
		ly:      AXIS_CENTER,
		rx:      AXIS_CENTER,
		ry:      AXIS_CENTER
	};

	// (v + 32768) * 255 / 65535 equals floor(x / 257) with x the biased value.
	// x >> 8 is the quotient or one above it.
	function automatic logic [7:0] scale_axis(input logic signed [15:0] v);
		logic [15:0] x;
		logic [7:0]  q;
		logic [16:0] prod;
		x = 16'(v) ^ 16'h8000;
		q = x[15:8];
		prod = {1'b0, q, 8'h00} + {9'd0, q};
		if (prod > {1'b0, x})
			q = q - 8'd1;
		return q;
	endfunction

	function automatic logic [3:0] hat_of(input logic [3:0] d);
		logic up, down, left, right;
		logic [3:0] h;
		up = d[0];
		down = d[1];
		left = d[2];
		right = d[3];
		if (up && right)        h = 4'd1;
		else if (up && left)    h = 4'd7;
		else if (down && right) h = 4'd3;
		else if (down && left)  h = 4'd5;
		else if (up)            h = 4'd0;
		else if (down)          h = 4'd4;
		else if (right)         h = 4'd2;
		else if (left)          h = 4'd6;
		else                    h = HAT_CENTER;
		return h;
	endfunction

	function automatic report_t build_report(input in_item_t it, input logic [7:0] thr);
		report_t r;
		r.buttons[5:0]  = it.face_buttons[5:0];
		r.buttons[6]    = (it.left_trigger >= thr);
		r.buttons[7]    = (it.right_trigger >= thr);
		r.buttons[11:8] = it.face_buttons[9:6];
		r.hat = hat_of(it.dpad);
		r.lx  = scale_axis(it.stick_lx);
		r.ly  = scale_axis(it.stick_ly);
		r.rx  = scale_axis(it.stick_rx);
		r.ry  = scale_axis(it.stick_ry);
		return r;
	endfunction

endpackage

// ----- hw/rtl/gamepad_report_format_and_send.sv -----
// Gamepad report formatter and IN-transfer launch control (top level).
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------
//  item    | in        | item_valid / item_stall | grfs_pkg::in_item_t
//  rpt     | out       | rpt_valid / rpt_stall   | grfs_pkg::out_item_t
//  apb     | in        | psel/penable/pwrite     | trigger_threshold @ 0x0
//
// One item per cycle sustained while rpt_stall is low; an accepted item passes the input register,
// then report build and flag update feeding the result register, which raises rpt_valid.
// The launch flags and stored reports update when an item moves into the result
// register, so the next item sees them in the following cycle.
// Reset clears all flags and stored reports to the neutral report; threshold to 32.
// A stalled result holds; one more item still enters the input register behind it.
`include "gamepad_report_format_and_send_defines.svh"

module gamepad_report_format_and_send (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  grfs_pkg::in_item_t            item,
	output logic                          rpt_valid,
	input  logic                          rpt_stall,
	output grfs_pkg::out_item_t           rpt,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [grfs_pkg::APB_AW-1:0]   paddr,
	input  logic [grfs_pkg::APB_DW-1:0]   pwdata,
	output logic [grfs_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	logic [7:0] threshold_q;

	logic                 valid_s1;
	grfs_pkg::in_item_t   item_s1;
	logic                 rpt_valid_q;
	grfs_pkg::out_item_t  rpt_q;

	grfs_pkg::report_t pending_q;
	// a single copy serves as both the last-sent and the in-flight report
	grfs_pkg::report_t sent_q;
	logic in_flight_q, dirty_q, has_sent_q, nn_seen_q;

	grfs_pkg::report_t   pending_nx, sent_nx, built;
	logic                in_flight_nx, dirty_nx, has_sent_nx, nn_seen_nx;
	logic                launch_req, started;
	grfs_pkg::out_item_t result;

	logic advance, accept;

	// ---- configuration port ----
	assign pready = 1'b1;
	assign prdata = (paddr[2] == grfs_pkg::REG_IDX_THRESHOLD) ?
		{{(grfs_pkg::APB_DW-8){1'b0}}, threshold_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= grfs_pkg::THRESHOLD_RESET;
		end else if (psel && penable && pwrite && pready &&
				paddr[2] == grfs_pkg::REG_IDX_THRESHOLD) begin
			threshold_q <= pwdata[7:0];
		end
	end

	// ---- handshake ----
	assign advance    = !rpt_valid_q || !rpt_stall;
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;
	assign rpt_valid  = rpt_valid_q;
	assign rpt        = rpt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// ---- report build and launch decision ----
	always_comb begin
		pending_nx   = pending_q;
		sent_nx      = sent_q;
		in_flight_nx = in_flight_q;
		dirty_nx     = dirty_q;
		has_sent_nx  = has_sent_q;
		nn_seen_nx   = nn_seen_q;
		launch_req   = 1'b0;
		built = item_s1.slot_active ? grfs_pkg::build_report(item_s1, threshold_q)
			: grfs_pkg::NEUTRAL_REPORT;

		unique case (grfs_pkg::kind_t'(item_s1.kind))
			grfs_pkg::KIND_INPUT: begin
				// until something non-neutral went out, neutral reports are recorded without a launch
				priority if (built == grfs_pkg::NEUTRAL_REPORT && !nn_seen_q) begin
					pending_nx = built;
					dirty_nx   = 1'b0;
				end else if (in_flight_q && built == sent_q) begin
					launch_req = 1'b0;
				end else if (dirty_q && built == pending_q) begin
					launch_req = 1'b1;
				end else if (!in_flight_q && has_sent_q && built == sent_q) begin
					launch_req = 1'b0;
				end else begin
					pending_nx = built;
					dirty_nx   = 1'b1;
					launch_req = 1'b1;
				end
			end
			grfs_pkg::KIND_DONE: begin
				in_flight_nx = 1'b0;
				launch_req   = dirty_q;
			end
			grfs_pkg::KIND_FAIL: begin
				in_flight_nx = 1'b0;
			end
			grfs_pkg::KIND_TICK: begin
				launch_req = dirty_q;
			end
			grfs_pkg::KIND_LINK_RESET: begin
				pending_nx   = grfs_pkg::NEUTRAL_REPORT;
				sent_nx      = grfs_pkg::NEUTRAL_REPORT;
				in_flight_nx = 1'b0;
				dirty_nx     = 1'b0;
				has_sent_nx  = 1'b0;
				nn_seen_nx   = 1'b0;
			end
			default: begin
				launch_req = 1'b0;
			end
		endcase

		started = launch_req && !in_flight_nx && item_s1.link_ready;
		if (started) begin
			sent_nx      = pending_nx;
			in_flight_nx = 1'b1;
			dirty_nx     = 1'b0;
			has_sent_nx  = 1'b1;
			if (pending_nx != grfs_pkg::NEUTRAL_REPORT)
				nn_seen_nx = 1'b1;
		end

		result.start_send   = started;
		result.out_buttons  = started ? sent_nx.buttons : 12'd0;
		result.out_hat      = started ? sent_nx.hat : 4'd0;
		result.out_lx       = started ? sent_nx.lx : 8'd0;
		result.out_ly       = started ? sent_nx.ly : 8'd0;
		result.out_rx       = started ? sent_nx.rx : 8'd0;
		result.out_ry       = started ? sent_nx.ry : 8'd0;
		result.busy_flag    = in_flight_nx;
		result.waiting_flag = dirty_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= grfs_pkg::NEUTRAL_REPORT;
			sent_q      <= grfs_pkg::NEUTRAL_REPORT;
			in_flight_q <= 1'b0;
			dirty_q     <= 1'b0;
			has_sent_q  <= 1'b0;
			nn_seen_q   <= 1'b0;
		end else if (advance && valid_s1) begin
			pending_q   <= pending_nx;
			sent_q      <= sent_nx;
			in_flight_q <= in_flight_nx;
			dirty_q     <= dirty_nx;
			has_sent_q  <= has_sent_nx;
			nn_seen_q   <= nn_seen_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (advance) begin
			rpt_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rpt_q <= result;
		end
	end

	// ---- checks ----
	`GRFS_ASSERT_IMP(a_busy_needs_sent, in_flight_q, has_sent_q)
	`GRFS_ASSERT_IMP(a_nn_needs_sent, nn_seen_q, has_sent_q)
	`GRFS_ASSERT_IMP(a_idle_fields_zero, rpt_valid_q && !rpt_q.start_send,
		rpt_q.out_buttons == 12'd0 && rpt_q.out_hat == 4'd0 && rpt_q.out_lx == 8'd0)
	`GRFS_ASSERT_IMP(a_launch_flags, rpt_valid_q && rpt_q.start_send,
		rpt_q.busy_flag && !rpt_q.waiting_flag)

endmodule
